[rtl/core/iau_pkg.sv]
// types and constants shared by the interval arithmetic unit
package iau_pkg;

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	typedef enum logic [2:0] {
		OP_INTERSECT  = 3'd0,
		OP_UNION      = 3'd1,
		OP_ADD        = 3'd2,
		OP_SUB        = 3'd3,
		OP_MUL        = 3'd4,
		OP_COMPARE    = 3'd5,
		OP_CONSTRAINT = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		REL_LT = 3'd0,
		REL_LE = 3'd1,
		REL_GT = 3'd2,
		REL_GE = 3'd3,
		REL_EQ = 3'd4,
		REL_NE = 3'd5
	} rel_t;

	typedef struct packed {
		op_t                operation;
		logic               a_unknown;
		logic signed [63:0] a_low;
		logic signed [63:0] a_high;
		logic               b_unknown;
		logic signed [63:0] b_low;
		logic signed [63:0] b_high;
		rel_t               relation;
		logic signed [63:0] constraint_value;
	} item_t;

	typedef struct packed {
		logic               r_unknown;
		logic signed [63:0] r_low;
		logic signed [63:0] r_high;
		logic               verdict_known;
		logic               verdict;
	} result_t;

	// result of the non-multiply paths plus what the multiply merge needs
	typedef struct packed {
		result_t r;
		logic    is_mul;
		logic    any_unknown;
	} front_t;

	// per-stage load enables
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

endpackage

[rtl/core/interval_arithmetic_unit.sv]
// Signed 64-bit interval arithmetic unit: intersect, union, add, subtract, multiply,
// relational compare and constraint-to-interval conversion on two intervals. The unit
// takes one item per cycle unless a stalled result has filled every stage; the depth
// is set by the four corner multipliers, each built from 32x32 partial products over
// magnitude, product, sum and sign-restore stages, followed by the min/max stage.
// Every stage holds its own valid bit and loads whenever it is empty or its successor
// moves, so bubbles close up under a stalled result and new items are taken while a
// finished result waits.
module interval_arithmetic_unit
	import iau_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic             v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic             rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
	stage_en_t        en;
	item_t            item_s1;
	front_t           front_s2, front_s3, front_s4, front_s5;
	logic [3:0][63:0] prod_s5;
	logic [3:0]       ovf_s5;
	result_t          result_s6;

	// stage load enables, from the output back
	assign rdy6 = !v_s6 || !result_stall;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign en.s2 = rdy2;
	assign en.s3 = rdy3;
	assign en.s4 = rdy4;
	assign en.s5 = rdy5;
	assign en.s6 = rdy6;

	assign item_stall   = !rdy1;
	assign result_valid = v_s6;
	assign result       = result_s6;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= item_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	// input beat register
	always_ff @(posedge clk) begin
		if (rdy1) begin
			item_s1 <= item;
		end
	end

	iau_front u_front (
		.clk      (clk),
		.en       (en),
		.item_s1  (item_s1),
		.front_s2 (front_s2)
	);

	// non-multiply result rides alongside the multipliers
	always_ff @(posedge clk) begin
		if (rdy3) front_s3 <= front_s2;
		if (rdy4) front_s4 <= front_s3;
		if (rdy5) front_s5 <= front_s4;
	end

	// corner products: al*bl, al*bh, ah*bl, ah*bh
	iau_mul u_mul0 (
		.clk(clk), .en(en), .x_s1(item_s1.a_low), .y_s1(item_s1.b_low),
		.prod_s5(prod_s5[0]), .ovf_s5(ovf_s5[0])
	);
	iau_mul u_mul1 (
		.clk(clk), .en(en), .x_s1(item_s1.a_low), .y_s1(item_s1.b_high),
		.prod_s5(prod_s5[1]), .ovf_s5(ovf_s5[1])
	);
	iau_mul u_mul2 (
		.clk(clk), .en(en), .x_s1(item_s1.a_high), .y_s1(item_s1.b_low),
		.prod_s5(prod_s5[2]), .ovf_s5(ovf_s5[2])
	);
	iau_mul u_mul3 (
		.clk(clk), .en(en), .x_s1(item_s1.a_high), .y_s1(item_s1.b_high),
		.prod_s5(prod_s5[3]), .ovf_s5(ovf_s5[3])
	);

	iau_select u_select (
		.clk       (clk),
		.en        (en),
		.front_s5  (front_s5),
		.prod_s5   (prod_s5),
		.ovf_s5    (ovf_s5),
		.result_s6 (result_s6)
	);

`ifndef NO_ASSERTIONS
	// input only stalls when every stage is occupied and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && result_stall))
		else $error("input stalled with room in the pipeline");

	// unknown results carry zero bounds
	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.r_unknown) |-> (result.r_low == '0 && result.r_high == '0))
		else $error("unknown result with nonzero bounds");

	// a decided verdict only comes from compare, which has no interval
	a_verdict_interval: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.verdict_known) |-> result.r_unknown)
		else $error("verdict with a known interval");

	// verdict true implies decided
	a_verdict_known: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.verdict) |-> result.verdict_known)
		else $error("verdict set while undecided");

	// a beat moving into the last stage shows up as valid next cycle
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && rdy6) |=> v_s6)
		else $error("pipeline beat lost at the output stage");
`endif

endmodule

[rtl/core/iau_front.sv]
// non-multiply operations: intersect, union, add, subtract, compare, constraint
module iau_front
	import iau_pkg::*;
(
	input  logic      clk,
	input  stage_en_t en,
	input  item_t     item_s1,
	output front_t    front_s2
);

	logic signed [63:0] al, ah, bl, bh, cv;
	logic               au, bu, any_unk;
	logic signed [63:0] add_lo, add_hi, sub_lo, sub_hi;
	logic               add_ovf, sub_ovf;
	logic               t, f, point, disjoint;
	logic               unk, vk, vv;
	logic signed [63:0] lo, hi;
	front_t             front;

	assign al = item_s1.a_low;
	assign ah = item_s1.a_high;
	assign bl = item_s1.b_low;
	assign bh = item_s1.b_high;
	assign cv = item_s1.constraint_value;
	assign au = item_s1.a_unknown;
	assign bu = item_s1.b_unknown;
	assign any_unk = au | bu;

	// bound sums and differences with signed overflow
	assign add_lo = al + bl;
	assign add_hi = ah + bh;
	assign sub_lo = al - bh;
	assign sub_hi = ah - bl;
	assign add_ovf = (~(al[63] ^ bl[63]) & (al[63] ^ add_lo[63]))
		| (~(ah[63] ^ bh[63]) & (ah[63] ^ add_hi[63]));
	assign sub_ovf = ((al[63] ^ bh[63]) & (al[63] ^ sub_lo[63]))
		| ((ah[63] ^ bl[63]) & (ah[63] ^ sub_hi[63]));

	// relation verdict terms
	assign point    = (al == ah) && (bl == bh) && (al == bl);
	assign disjoint = (ah < bl) || (bh < al);

	always_comb begin
		t = 1'b0;
		f = 1'b0;
		case (item_s1.relation)
			REL_LT: begin
				t = ah < bl;
				f = !(al < bh);
			end
			REL_LE: begin
				t = !(bl < ah);
				f = bh < al;
			end
			REL_GT: begin
				t = bh < al;
				f = !(bl < ah);
			end
			REL_GE: begin
				t = !(al < bh);
				f = ah < bl;
			end
			REL_EQ: begin
				t = point;
				f = disjoint;
			end
			REL_NE: begin
				t = disjoint;
				f = point;
			end
			default: begin
				t = 1'b0;
				f = 1'b0;
			end
		endcase
	end

	// operation select
	always_comb begin
		unk = 1'b1;
		lo  = '0;
		hi  = '0;
		vk  = 1'b0;
		vv  = 1'b0;
		case (item_s1.operation)
			OP_INTERSECT: begin
				if (au) begin
					unk = bu;
					lo  = bl;
					hi  = bh;
				end else if (bu) begin
					unk = 1'b0;
					lo  = al;
					hi  = ah;
				end else begin
					unk = 1'b0;
					lo  = (al < bl) ? bl : al;
					hi  = (bh < ah) ? bh : ah;
				end
			end
			OP_UNION: begin
				unk = any_unk;
				lo  = (bl < al) ? bl : al;
				hi  = (ah < bh) ? bh : ah;
			end
			OP_ADD: begin
				unk = any_unk | add_ovf;
				lo  = add_lo;
				hi  = add_hi;
			end
			OP_SUB: begin
				unk = any_unk | sub_ovf;
				lo  = sub_lo;
				hi  = sub_hi;
			end
			OP_MUL: begin
				// merged after the multipliers
				unk = any_unk;
			end
			OP_COMPARE: begin
				unk = 1'b1;
				vk  = (t | f) & ~any_unk;
				vv  = t & ~any_unk;
			end
			OP_CONSTRAINT: begin
				case (item_s1.relation)
					REL_LT: begin
						unk = (cv == S64_MIN);
						lo  = S64_MIN;
						hi  = cv - 64'sd1;
					end
					REL_LE: begin
						unk = 1'b0;
						lo  = S64_MIN;
						hi  = cv;
					end
					REL_GT: begin
						unk = (cv == S64_MAX);
						lo  = cv + 64'sd1;
						hi  = S64_MAX;
					end
					REL_GE: begin
						unk = 1'b0;
						lo  = cv;
						hi  = S64_MAX;
					end
					REL_EQ: begin
						unk = 1'b0;
						lo  = cv;
						hi  = cv;
					end
					default: begin
						unk = 1'b1;
					end
				endcase
			end
			default: begin
				unk = 1'b1;
			end
		endcase
	end

	// unknown results carry zero bounds
	always_comb begin
		front.r.r_unknown     = unk;
		front.r.r_low         = unk ? '0 : lo;
		front.r.r_high        = unk ? '0 : hi;
		front.r.verdict_known = vk;
		front.r.verdict       = vk & vv;
		front.is_mul          = (item_s1.operation == OP_MUL);
		front.any_unknown     = any_unk;
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			front_s2 <= front;
		end
	end

endmodule

[rtl/core/iau_mul.sv]
// one signed 64x64 corner product from 32x32 partial products, with overflow
module iau_mul
	import iau_pkg::*;
(
	input  logic               clk,
	input  stage_en_t          en,
	input  logic signed [63:0] x_s1,
	input  logic signed [63:0] y_s1,
	output logic signed [63:0] prod_s5,
	output logic               ovf_s5
);

	localparam logic [63:0] SIGN_MAG = 64'h8000_0000_0000_0000;

	logic [63:0]  mx_s2, my_s2;
	logic         neg_s2, neg_s3, neg_s4;
	logic [63:0]  ll_s3, lh_s3, hl_s3, hh_s3;
	logic [127:0] p_s4;
	logic [63:0]  lo;
	logic         ovf;

	// stage 2: magnitudes and product sign
	always_ff @(posedge clk) begin
		if (en.s2) begin
			mx_s2  <= x_s1[63] ? (64'd0 - x_s1) : x_s1;
			my_s2  <= y_s1[63] ? (64'd0 - y_s1) : y_s1;
			neg_s2 <= x_s1[63] ^ y_s1[63];
		end
	end

	// stage 3: four 32x32 partial products
	always_ff @(posedge clk) begin
		if (en.s3) begin
			ll_s3  <= mx_s2[31:0]  * my_s2[31:0];
			lh_s3  <= mx_s2[31:0]  * my_s2[63:32];
			hl_s3  <= mx_s2[63:32] * my_s2[31:0];
			hh_s3  <= mx_s2[63:32] * my_s2[63:32];
			neg_s3 <= neg_s2;
		end
	end

	// stage 4: 128-bit magnitude product
	always_ff @(posedge clk) begin
		if (en.s4) begin
			p_s4 <= {64'd0, ll_s3} + {32'd0, lh_s3, 32'd0}
				+ {32'd0, hl_s3, 32'd0} + {hh_s3, 64'd0};
			neg_s4 <= neg_s3;
		end
	end

	// stage 5: range check and sign restore
	assign lo  = p_s4[63:0];
	assign ovf = (|p_s4[127:64]) | (neg_s4 ? (lo > SIGN_MAG) : lo[63]);

	always_ff @(posedge clk) begin
		if (en.s5) begin
			prod_s5 <= neg_s4 ? (64'sd0 - $signed(lo)) : $signed(lo);
			ovf_s5  <= ovf;
		end
	end

endmodule

[rtl/core/iau_select.sv]
// min and max of the corner products and final result merge
module iau_select
	import iau_pkg::*;
(
	input  logic                   clk,
	input  stage_en_t              en,
	input  front_t                 front_s5,
	input  logic [3:0][63:0]       prod_s5,
	input  logic [3:0]             ovf_s5,
	output result_t                result_s6
);

	logic signed [63:0] p0, p1, p2, p3;
	logic signed [63:0] mn01, mn23, mx01, mx23, mn, mx;
	logic               unk;
	result_t            res;

	assign p0 = prod_s5[0];
	assign p1 = prod_s5[1];
	assign p2 = prod_s5[2];
	assign p3 = prod_s5[3];

	// two-level compare tree
	assign mn01 = (p1 < p0) ? p1 : p0;
	assign mn23 = (p3 < p2) ? p3 : p2;
	assign mx01 = (p0 < p1) ? p1 : p0;
	assign mx23 = (p2 < p3) ? p3 : p2;
	assign mn   = (mn23 < mn01) ? mn23 : mn01;
	assign mx   = (mx01 < mx23) ? mx23 : mx01;

	assign unk = front_s5.any_unknown | (|ovf_s5);

	always_comb begin
		if (front_s5.is_mul) begin
			res.r_unknown     = unk;
			res.r_low         = unk ? '0 : mn;
			res.r_high        = unk ? '0 : mx;
			res.verdict_known = 1'b0;
			res.verdict       = 1'b0;
		end else begin
			res = front_s5.r;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			result_s6 <= res;
		end
	end

endmodule

[tb/sv/tb.sv]
// self-checking testbench for the interval arithmetic unit
module tb;
	import iau_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	// results still owed by the unit, oldest first
	result_t     pending_results[$];
	int unsigned mismatch_count;
	int unsigned burst_left;

	interval_arithmetic_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// 50 MHz clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// independent interval result for one item
	function automatic result_t predict_interval_op(item_t it);
		result_t            r;
		logic signed [63:0] al, ah, bl, bh, v, lo, hi;
		logic signed [63:0] x, y;
		logic signed [63:0] corner [4];
		logic        [64:0] sum_lo, sum_hi;
		logic       [127:0] wide;
		logic               unk, ovf, t, f, point, disjoint;
		int                 k;
		al = it.a_low;
		ah = it.a_high;
		bl = it.b_low;
		bh = it.b_high;
		v = it.constraint_value;
		unk = 1'b0;
		ovf = 1'b0;
		t = 1'b0;
		f = 1'b0;
		lo = '0;
		hi = '0;
		case (it.operation)
			OP_INTERSECT: begin
				// an unknown side yields the other side unchanged
				if (it.a_unknown) begin
					unk = it.b_unknown;
					lo = bl;
					hi = bh;
				end else if (it.b_unknown) begin
					lo = al;
					hi = ah;
				end else begin
					lo = (al > bl) ? al : bl;
					hi = (ah < bh) ? ah : bh;
				end
			end
			OP_UNION: begin
				unk = it.a_unknown | it.b_unknown;
				lo = (al < bl) ? al : bl;
				hi = (ah > bh) ? ah : bh;
			end
			OP_ADD, OP_SUB: begin
				// 65-bit sums, overflow when the top two bits differ
				if (it.operation == OP_ADD) begin
					sum_lo = {al[63], al} + {bl[63], bl};
					sum_hi = {ah[63], ah} + {bh[63], bh};
				end else begin
					sum_lo = {al[63], al} - {bh[63], bh};
					sum_hi = {ah[63], ah} - {bl[63], bl};
				end
				ovf = (sum_lo[64] != sum_lo[63]) || (sum_hi[64] != sum_hi[63]);
				unk = it.a_unknown | it.b_unknown | ovf;
				lo = sum_lo[63:0];
				hi = sum_hi[63:0];
			end
			OP_MUL: begin
				// full 128-bit corner products, overflow when they do not fit 64 bits
				for (k = 0; k < 4; k++) begin
					x = (k < 2) ? al : ah;
					y = k[0] ? bh : bl;
					wide = {{64{x[63]}}, x} * {{64{y[63]}}, y};
					if (wide[127:63] != {65{wide[63]}})
						ovf = 1'b1;
					corner[k] = wide[63:0];
				end
				lo = corner[0];
				hi = corner[0];
				for (k = 1; k < 4; k++) begin
					if (corner[k] < lo)
						lo = corner[k];
					if (corner[k] > hi)
						hi = corner[k];
				end
				unk = it.a_unknown | it.b_unknown | ovf;
			end
			OP_COMPARE: begin
				unk = 1'b1;
				point = (al == ah) && (bl == bh) && (al == bl);
				disjoint = (ah < bl) || (bh < al);
				case (it.relation)
					REL_LT: begin t = ah < bl;  f = al >= bh; end
					REL_LE: begin t = ah <= bl; f = al > bh;  end
					REL_GT: begin t = al > bh;  f = ah <= bl; end
					REL_GE: begin t = al >= bh; f = ah < bl;  end
					REL_EQ: begin t = point;    f = disjoint; end
					REL_NE: begin t = disjoint; f = point;    end
					default: ;
				endcase
				if (it.a_unknown || it.b_unknown) begin
					t = 1'b0;
					f = 1'b0;
				end
			end
			OP_CONSTRAINT: begin
				// half-open relations at the range edge have no interval
				case (it.relation)
					REL_LT: begin unk = (v == S64_MIN); lo = S64_MIN; hi = v - 64'sd1; end
					REL_LE: begin lo = S64_MIN; hi = v; end
					REL_GT: begin unk = (v == S64_MAX); lo = v + 64'sd1; hi = S64_MAX; end
					REL_GE: begin lo = v; hi = S64_MAX; end
					REL_EQ: begin lo = v; hi = v; end
					default: unk = 1'b1;
				endcase
			end
			default: unk = 1'b1;
		endcase
		r.r_unknown = unk;
		r.r_low = unk ? '0 : lo;
		r.r_high = unk ? '0 : hi;
		r.verdict_known = t | f;
		r.verdict = t;
		return r;
	endfunction

	function automatic item_t make_item(op_t op, logic au, logic signed [63:0] al,
		logic signed [63:0] ah, logic bu, logic signed [63:0] bl, logic signed [63:0] bh,
		rel_t rel, logic signed [63:0] v);
		item_t it;
		it.operation = op;
		it.a_unknown = au;
		it.a_low = al;
		it.a_high = ah;
		it.b_unknown = bu;
		it.b_low = bl;
		it.b_high = bh;
		it.relation = rel;
		it.constraint_value = v;
		return it;
	endfunction

	// bound values weighted toward edges, small numbers and products that just fit
	function automatic logic signed [63:0] pick_bound();
		logic signed [63:0] w;
		w = {$urandom(), $urandom()};
		case ($urandom_range(0, 9))
			0: w = S64_MIN + 64'($urandom_range(0, 3));
			1: w = S64_MAX - 64'($urandom_range(0, 3));
			2, 3: begin
				w = 64'($urandom_range(0, 400));
				w = w - 64'sd200;
			end
			4, 5: w = 64'($signed($urandom()));
			6, 7: w = w >>> $urandom_range(1, 62);
			default: ;
		endcase
		return w;
	endfunction

	// mostly ordered intervals, some unknown, a few reserved codes
	function automatic item_t random_item();
		item_t              it;
		logic signed [63:0] swap;
		if ($urandom_range(0, 49) == 0)
			it.operation = op_t'(3'd7);
		else
			it.operation = op_t'(3'($urandom_range(0, 6)));
		if ($urandom_range(0, 49) == 0)
			it.relation = rel_t'(3'($urandom_range(6, 7)));
		else
			it.relation = rel_t'(3'($urandom_range(0, 5)));
		it.a_unknown = ($urandom_range(0, 6) == 0);
		it.b_unknown = ($urandom_range(0, 6) == 0);
		it.a_low = pick_bound();
		it.a_high = pick_bound();
		it.b_low = pick_bound();
		it.b_high = pick_bound();
		if ($urandom_range(0, 6) != 0 && it.a_low > it.a_high) begin
			swap = it.a_low;
			it.a_low = it.a_high;
			it.a_high = swap;
		end
		if ($urandom_range(0, 6) != 0 && it.b_low > it.b_high) begin
			swap = it.b_low;
			it.b_low = it.b_high;
			it.b_high = swap;
		end
		// same single point on both sides so equality can be decided
		if (it.operation == OP_COMPARE && $urandom_range(0, 5) == 0) begin
			it.a_high = it.a_low;
			it.b_low = it.a_low;
			it.b_high = it.a_low;
		end
		it.constraint_value = pick_bound();
		return it;
	endfunction

	// one item beat, with bursts and random gaps between them
	task automatic send_item(input item_t it);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90)
				: $urandom_range(1, 8);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		pending_results = {pending_results, predict_interval_op(it)};
	endtask

	task automatic test_intersect_union();
		send_item(make_item(OP_INTERSECT, 1, 5, 9, 0, -3, 4, REL_LT, 0));
		send_item(make_item(OP_INTERSECT, 0, S64_MIN, S64_MAX, 1, 7, 7, REL_LT, 0));
		send_item(make_item(OP_INTERSECT, 0, -20, -10, 0, 10, 20, REL_LT, 0));
		send_item(make_item(OP_UNION, 0, S64_MIN, 0, 0, -1, S64_MAX, REL_LT, 0));
	endtask

	task automatic test_add_sub();
		send_item(make_item(OP_ADD, 0, 0, S64_MAX, 0, 0, 1, REL_LT, 0));
		send_item(make_item(OP_ADD, 0, S64_MIN, 0, 0, -1, 5, REL_LT, 0));
		send_item(make_item(OP_SUB, 0, S64_MIN, 5, 0, 0, 1, REL_LT, 0));
	endtask

	task automatic test_multiply();
		send_item(make_item(OP_MUL, 0, -3, 7, 0, -5, 2, REL_LT, 0));
		send_item(make_item(OP_MUL, 0, S64_MIN, S64_MIN, 0, -1, -1, REL_LT, 0));
	endtask

	task automatic test_compare();
		send_item(make_item(OP_COMPARE, 0, 1, 3, 0, 4, 9, REL_LT, 0));
		send_item(make_item(OP_COMPARE, 0, 5, 9, 0, 1, 4, REL_LE, 0));
		send_item(make_item(OP_COMPARE, 0, 0, 10, 0, 5, 6, REL_GT, 0));
		send_item(make_item(OP_COMPARE, 0, S64_MAX, S64_MAX, 0, S64_MIN, S64_MAX,
			REL_GE, 0));
		send_item(make_item(OP_COMPARE, 0, 7, 7, 0, 7, 7, REL_EQ, 0));
		send_item(make_item(OP_COMPARE, 0, 1, 3, 1, 8, 9, REL_NE, 0));
	endtask

	task automatic test_constraint();
		send_item(make_item(OP_CONSTRAINT, 0, 0, 0, 0, 0, 0, REL_LT, S64_MIN));
		send_item(make_item(OP_CONSTRAINT, 1, 0, 0, 1, 0, 0, REL_GT, S64_MAX));
		send_item(make_item(OP_CONSTRAINT, 0, 0, 0, 0, 0, 0, REL_NE, 42));
		send_item(make_item(OP_CONSTRAINT, 0, 0, 0, 0, 0, 0, REL_LE, S64_MAX));
		send_item(make_item(OP_CONSTRAINT, 0, 0, 0, 0, 0, 0, REL_EQ, S64_MIN));
	endtask

	// reserved operation and relation codes
	task automatic test_reserved_codes();
		send_item(make_item(op_t'(3'd7), 0, 1, 2, 0, 3, 4, REL_LT, 0));
		send_item(make_item(OP_COMPARE, 0, 1, 3, 0, 4, 9, rel_t'(3'd6), 0));
		send_item(make_item(OP_CONSTRAINT, 0, 0, 0, 0, 0, 0, rel_t'(3'd7), 5));
	endtask

	task automatic test_random();
		int n;
		for (n = 0; n < 1800; n++)
			send_item(random_item());
	endtask

	// result side backpressure: free, random, periodic and solid stretches
	initial begin : result_stall_pattern
		int unsigned mode, len, pct, period, n;
		result_stall <= 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(10, 80);
			pct = $urandom_range(10, 85);
			period = $urandom_range(2, 7);
			for (n = 0; n < len; n++) begin
				@(posedge clk);
				case (mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 99) < pct);
					2: result_stall <= (n % period == 0);
					default: result_stall <= (n < len / 4);
				endcase
			end
		end
	end

	task automatic report_mismatch(input string what, input result_t want, input result_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%s: expected unk=%0b low=%0d high=%0d vk=%0b v=%0b",
				what, want.r_unknown, want.r_low, want.r_high, want.verdict_known,
				want.verdict);
			$display("    got unk=%0b low=%0d high=%0d vk=%0b v=%0b",
				got.r_unknown, got.r_low, got.r_high, got.verdict_known, got.verdict);
		end
	endtask

	// compare each result beat with the oldest pending prediction
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result beat", '0, result);
			end else begin
				want = pending_results.pop_front();
				if (want.r_unknown !== result.r_unknown || want.r_low !== result.r_low ||
					want.r_high !== result.r_high ||
					want.verdict_known !== result.verdict_known ||
					want.verdict !== result.verdict)
					report_mismatch("result mismatch", want, result);
			end
		end
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		mismatch_count = 0;
		burst_left = 0;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_intersect_union();
		test_add_sub();
		test_multiply();
		test_compare();
		test_constraint();
		test_reserved_codes();
		test_random();
		item_valid <= 1'b0;

		// drain the pipeline, then wait on for stray beats
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/core/iau_pkg.sv
rtl/core/iau_front.sv
rtl/core/iau_mul.sv
rtl/core/iau_select.sv
rtl/core/interval_arithmetic_unit.sv
tb/sv/tb.sv
